// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during reset
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property form, prop may use |-> or |=>
`define NSD_ASSERT_PROP(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// plain invariant checked at every clock edge
`define NSD_ASSERT_ALWAYS(label, cond) \
    `NSD_ASSERT_PROP(label, (1'b1 |-> (cond)))

`else

`define NSD_ASSERT_PROP(label, prop)
`define NSD_ASSERT_ALWAYS(label, cond)

`endif

`endif

// ===== rtl/nsd_pkg.sv =====
// ------------------------------------------------------------------------
// nsd_pkg
// shared types, byte codes and helper functions of the sentence deframer
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsd_pkg;

    localparam logic [7:0] HEAD_BYTE = 8'h24;
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    // sentence positions that carry the three type letters, head is position 0
    localparam logic [7:0] TYPE_POS_0 = 8'd3;
    localparam logic [7:0] TYPE_POS_1 = 8'd4;
    localparam logic [7:0] TYPE_POS_2 = 8'd5;

    typedef enum logic [2:0] {
        MSG_GGA     = 3'd0,
        MSG_RMC     = 3'd1,
        MSG_FPD     = 3'd2,
        MSG_IMU     = 3'd3,
        MSG_UNKNOWN = 3'd4
    } frame_kind_t;

    typedef struct packed {
        logic        checksum_ok;
        frame_kind_t frame_kind;
        logic [7:0]  received_checksum;
        logic [7:0]  computed_checksum;
        logic [7:0]  sentence_length;
        logic        overflowed;
    } nsd_result_t;

    // bytes other than 0-9 and uppercase A-F pass through raw
    function automatic logic [7:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        begin
            v = ch;
            if (ch inside {[8'h30:8'h39]})
            begin
                v = ch - 8'h30;
            end
            else if (ch inside {[8'h41:8'h46]})
            begin
                v = ch - 8'h37;
            end
            return v;
        end
    endfunction

    function automatic frame_kind_t classify(input logic [23:0] chars);
        frame_kind_t t;
        begin
            if (chars == "GGA")
            begin
                t = MSG_GGA;
            end
            else if (chars == "RMC")
            begin
                t = MSG_RMC;
            end
            else if (chars == "FPD")
            begin
                t = MSG_FPD;
            end
            else if (chars == "IMU")
            begin
                t = MSG_IMU;
            end
            else
            begin
                t = MSG_UNKNOWN;
            end
            return t;
        end
    endfunction

endpackage

// ===== rtl/nsd_out_reg.sv =====
// ------------------------------------------------------------------------
// nsd_out_reg
// result register with valid/ready handshake toward the consumer
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  nsd_pkg::nsd_result_t load_data,
    output logic                out_valid,
    input  logic                out_ready,
    output nsd_pkg::nsd_result_t data
);
    import nsd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    nsd_result_t data_reg;
    nsd_result_t data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        // load is only raised when the slot is free or drains this cycle
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

// ===== rtl/nmea_sentence_deframer.sv =====
// ------------------------------------------------------------------------
// nmea_sentence_deframer
// sentence framing, xor checksum check and type decode of a serial byte stream
// ------------------------------------------------------------------------
// Takes one byte per clock cycle while in_ready is high. A result appears in
// the output register in the cycle after the second checksum digit is taken.
// While a result waits in that register, in_ready drops only for the byte
// that would finish the next sentence; every other byte is still taken at
// one per cycle. The single output register is what sets this limit.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module nmea_sentence_deframer #(
    parameter int MAX_SENTENCE_LEN = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       checksum_ok,
    output logic [2:0] frame_kind,
    output logic [7:0] received_checksum,
    output logic [7:0] computed_checksum,
    output logic [7:0] sentence_length,
    output logic       overflowed
);
    import nsd_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_SENTENCE_LEN);

    logic        in_sentence_reg, in_sentence_next;
    logic        after_star_reg, after_star_next;
    logic        first_seen_reg, first_seen_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [7:0]  first_digit_reg, first_digit_next;
    logic [7:0]  byte_position_reg, byte_position_next;
    logic [7:0]  type_chars_reg [3];
    logic [7:0]  type_chars_next [3];
    logic        overflow_seen_reg, overflow_seen_next;

    logic        in_fire;
    logic        last_digit;
    logic        res_load;
    nsd_result_t res;
    nsd_result_t out_data;
    logic [7:0]  hv_first;
    logic [7:0]  hv_cur;
    logic [7:0]  rx_cs;

    // next byte closes a sentence and needs a free result slot
    assign last_digit = in_sentence_reg && after_star_reg && first_seen_reg;
    assign in_ready   = !last_digit || !out_valid || out_ready;
    assign in_fire    = in_valid && in_ready;

    assign hv_first = hex_value(first_digit_reg);
    assign hv_cur   = hex_value(rx_byte);
    assign rx_cs    = {hv_first[3:0], 4'b0000} | hv_cur;

    always_comb
    begin
        in_sentence_next   = in_sentence_reg;
        after_star_next    = after_star_reg;
        first_seen_next    = first_seen_reg;
        running_xor_next   = running_xor_reg;
        first_digit_next   = first_digit_reg;
        byte_position_next = byte_position_reg;
        overflow_seen_next = overflow_seen_reg;
        type_chars_next    = type_chars_reg;
        res_load           = 1'b0;

        if (in_fire)
        begin
            if (!in_sentence_reg)
            begin
                if (rx_byte == HEAD_BYTE)
                begin
                    in_sentence_next   = 1'b1;
                    after_star_next    = 1'b0;
                    first_seen_next    = 1'b0;
                    running_xor_next   = 8'h00;
                    first_digit_next   = 8'h00;
                    byte_position_next = 8'd1;
                    overflow_seen_next = 1'b0;
                    type_chars_next[0] = 8'h00;
                    type_chars_next[1] = 8'h00;
                    type_chars_next[2] = 8'h00;
                end
            end
            else
            begin
                case (byte_position_reg)
                    TYPE_POS_0: type_chars_next[0] = rx_byte;
                    TYPE_POS_1: type_chars_next[1] = rx_byte;
                    TYPE_POS_2: type_chars_next[2] = rx_byte;
                    default:    ;
                endcase

                // length saturates, overflow sticks until the next head
                if (byte_position_reg >= MAX_LEN)
                begin
                    overflow_seen_next = 1'b1;
                end
                else
                begin
                    byte_position_next = byte_position_reg + 8'd1;
                end

                if (after_star_reg)
                begin
                    if (!first_seen_reg)
                    begin
                        first_digit_next = rx_byte;
                        first_seen_next  = 1'b1;
                    end
                    else
                    begin
                        res_load         = 1'b1;
                        in_sentence_next = 1'b0;
                        after_star_next  = 1'b0;
                        first_seen_next  = 1'b0;
                    end
                end
                else if (rx_byte == STAR_BYTE)
                begin
                    after_star_next = 1'b1;
                end
                else
                begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                end
            end
        end
    end

    always_comb
    begin
        res.checksum_ok       = (rx_cs == running_xor_reg);
        res.frame_kind        = classify({type_chars_next[0], type_chars_next[1],
                                          type_chars_next[2]});
        res.received_checksum = rx_cs;
        res.computed_checksum = running_xor_reg;
        res.sentence_length   = byte_position_next;
        res.overflowed        = overflow_seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg   <= 1'b0;
            after_star_reg    <= 1'b0;
            first_seen_reg    <= 1'b0;
            running_xor_reg   <= 8'h00;
            first_digit_reg   <= 8'h00;
            byte_position_reg <= 8'd0;
            overflow_seen_reg <= 1'b0;
            type_chars_reg[0] <= 8'h00;
            type_chars_reg[1] <= 8'h00;
            type_chars_reg[2] <= 8'h00;
        end
        else
        begin
            in_sentence_reg   <= in_sentence_next;
            after_star_reg    <= after_star_next;
            first_seen_reg    <= first_seen_next;
            running_xor_reg   <= running_xor_next;
            first_digit_reg   <= first_digit_next;
            byte_position_reg <= byte_position_next;
            overflow_seen_reg <= overflow_seen_next;
            type_chars_reg    <= type_chars_next;
        end
    end

    nsd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (out_data)
    );

    assign checksum_ok       = out_data.checksum_ok;
    assign frame_kind        = out_data.frame_kind;
    assign received_checksum = out_data.received_checksum;
    assign computed_checksum = out_data.computed_checksum;
    assign sentence_length   = out_data.sentence_length;
    assign overflowed        = out_data.overflowed;

    `NSD_ASSERT_PROP(a_result_follows_last_digit, (in_fire && last_digit) |=> out_valid)
    `NSD_ASSERT_ALWAYS(a_position_bounded, byte_position_reg <= MAX_LEN)
    `NSD_ASSERT_ALWAYS(a_idle_clean, in_sentence_reg || (!after_star_reg && !first_seen_reg))
    `NSD_ASSERT_ALWAYS(a_overflow_length, !(out_valid && overflowed) || sentence_length == MAX_LEN)

endmodule

// ===== verif/nmea_sentence_deframer_tb.sv =====
// ------------------------------------------------------------------------
// nmea_sentence_deframer_tb
// self-checking bench: random nmea-style byte streams with valid/ready
// stalls on both sides, every completed sentence checked field by field
// against a cycle-free prediction of the framer
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_sentence_deframer_tb;

    import nsd_pkg::*;

    localparam int          MAX_LEN     = 128;
    localparam int          BYTE_TARGET = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // tracks the framer state and holds the sentences still owed by the block
    class deframe_scoreboard;
        bit               in_sent;
        bit               star_seen;
        bit               have_first;
        logic [7:0]       xor_acc;
        logic [7:0]       first_char;
        logic [7:0]       pos;
        logic [7:0]       type_buf [3];
        bit               long_seen;
        nsd_result_t      pending_sentences [$];
        int               errors;

        function new();
            clear_frame();
            in_sent = 1'b0;
            errors  = 0;
        endfunction

        function void clear_frame();
            star_seen  = 1'b0;
            have_first = 1'b0;
            xor_acc    = 8'h00;
            first_char = 8'h00;
            pos        = 8'h00;
            type_buf   = '{8'h00, 8'h00, 8'h00};
            long_seen  = 1'b0;
        endfunction

        function logic [7:0] digit_value(input logic [7:0] ch);
            if (ch >= "0" && ch <= "9")
                return ch - "0";
            if (ch >= "A" && ch <= "F")
                return ch - "A" + 8'd10;
            return ch;
        endfunction

        function frame_kind_t sentence_kind();
            logic [23:0] t;
            t = {type_buf[0], type_buf[1], type_buf[2]};
            if (t == "GGA") return MSG_GGA;
            if (t == "RMC") return MSG_RMC;
            if (t == "FPD") return MSG_FPD;
            if (t == "IMU") return MSG_IMU;
            return MSG_UNKNOWN;
        endfunction

        function void count_position(input logic [7:0] c);
            if (pos >= 3 && pos <= 5)
                type_buf[pos - 3] = c;
            if (pos >= MAX_LEN)
                long_seen = 1'b1;
            else
                pos = pos + 8'd1;
        endfunction

        // one accepted transaction; returns 0 if the framer just drops it
        function bit note_byte(input logic [7:0] c);
            nsd_result_t r;
            logic [7:0]  rx;
            if (!in_sent)
            begin
                if (c != HEAD_BYTE)
                    return 1'b0;
                clear_frame();
                in_sent = 1'b1;
                count_position(c);
                return 1'b1;
            end
            count_position(c);
            if (star_seen)
            begin
                if (!have_first)
                begin
                    first_char = c;
                    have_first = 1'b1;
                    return 1'b1;
                end
                rx = (digit_value(first_char) << 4) | digit_value(c);
                r.checksum_ok       = (rx == xor_acc);
                r.frame_kind        = sentence_kind();
                r.received_checksum = rx;
                r.computed_checksum = xor_acc;
                r.sentence_length   = pos;
                r.overflowed        = long_seen;
                pending_sentences.push_back(r);
                in_sent    = 1'b0;
                star_seen  = 1'b0;
                have_first = 1'b0;
                return 1'b1;
            end
            if (c == STAR_BYTE)
                star_seen = 1'b1;
            else
                xor_acc = xor_acc ^ c;
            return 1'b1;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_sentence(input nsd_result_t got);
            nsd_result_t want;
            if (pending_sentences.size() == 0)
            begin
                report_mismatch("result with nothing outstanding");
                return;
            end
            want = pending_sentences.pop_front();
            if (got.checksum_ok !== want.checksum_ok)
                report_mismatch($sformatf("checksum_ok got %b want %b",
                                          got.checksum_ok, want.checksum_ok));
            if (got.frame_kind !== want.frame_kind)
                report_mismatch($sformatf("frame_kind got %0d want %0d",
                                          got.frame_kind, want.frame_kind));
            if (got.received_checksum !== want.received_checksum)
                report_mismatch($sformatf("received_checksum got %h want %h",
                                          got.received_checksum, want.received_checksum));
            if (got.computed_checksum !== want.computed_checksum)
                report_mismatch($sformatf("computed_checksum got %h want %h",
                                          got.computed_checksum, want.computed_checksum));
            if (got.sentence_length !== want.sentence_length)
                report_mismatch($sformatf("sentence_length got %0d want %0d",
                                          got.sentence_length, want.sentence_length));
            if (got.overflowed !== want.overflowed)
                report_mismatch($sformatf("overflowed got %b want %b",
                                          got.overflowed, want.overflowed));
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       checksum_ok;
    logic [2:0] frame_kind;
    logic [7:0] received_checksum;
    logic [7:0] computed_checksum;
    logic [7:0] sentence_length;
    logic       overflowed;

    deframe_scoreboard sb = new();
    bit                calm = 1'b0;
    int                used_bytes = 0;
    int unsigned       cycle_count = 0;
    logic [7:0]        frame [$];

    always #4 clk = ~clk;

    nmea_sentence_deframer #(
        .MAX_SENTENCE_LEN (MAX_LEN)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .checksum_ok       (checksum_ok),
        .frame_kind        (frame_kind),
        .received_checksum (received_checksum),
        .computed_checksum (computed_checksum),
        .sentence_length   (sentence_length),
        .overflowed        (overflowed)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("nmea_sentence_deframer_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_sentence(nsd_result_t'({checksum_ok, frame_kind, received_checksum,
                                             computed_checksum, sentence_length,
                                             overflowed}));
    end

    task send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        if (sb.note_byte(b))
            used_bytes++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function logic [7:0] hex_char(input logic [3:0] n);
        string digits;
        digits = "0123456789ABCDEF";
        return digits[n];
    endfunction

    function logic [7:0] any_but_star(input bit printable);
        logic [7:0] c;
        do
            c = printable ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(0, 255));
        while (c == STAR_BYTE);
        return c;
    endfunction

    function logic [7:0] odd_digit();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range("a", "f"));
            1: return STAR_BYTE;
            2: return hex_char(4'($urandom));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // builds the next random transaction group into frame
    task make_sentence();
        int         kind;
        int         body_len;
        int         hdr_len;
        bit         printable;
        logic [7:0] sum;
        string      kinds [4];
        string      tag;
        kinds = '{"GGA", "RMC", "FPD", "IMU"};
        frame.delete();
        kind = $urandom_range(0, 99);
        if (kind < 78)
        begin
            frame.push_back(HEAD_BYTE);
            if ($urandom_range(0, 9) == 0)
            begin
                // too short to carry the type letters
                hdr_len = $urandom_range(0, 4);
                for (int i = 0; i < hdr_len; i++)
                    frame.push_back(8'($urandom_range("A", "Z")));
            end
            else
            begin
                frame.push_back("G");
                frame.push_back($urandom_range(0, 1) ? "P" : "N");
                if ($urandom_range(0, 4) == 4)
                    for (int i = 0; i < 3; i++)
                        frame.push_back(8'($urandom_range("A", "Z")));
                else
                begin
                    tag = kinds[$urandom_range(0, 3)];
                    for (int i = 0; i < 3; i++)
                        frame.push_back(tag[i]);
                end
                body_len  = ($urandom_range(0, 99) < 4) ? $urandom_range(110, 140)
                                                         : $urandom_range(0, 24);
                printable = ($urandom_range(0, 9) < 7);
                for (int i = 0; i < body_len; i++)
                    frame.push_back(any_but_star(printable));
            end
            sum = 8'h00;
            for (int i = 1; i < frame.size(); i++)
                sum ^= frame[i];
            frame.push_back(STAR_BYTE);
            if ($urandom_range(0, 99) < 80)
            begin
                frame.push_back(hex_char(sum[7:4]));
                frame.push_back(hex_char(sum[3:0]));
            end
            else
            begin
                frame.push_back($urandom_range(0, 1) ? odd_digit() : hex_char(sum[7:4]));
                frame.push_back(odd_digit());
            end
        end
        else if (kind < 90)
        begin
            // broken sentence, may leave the framer mid-sentence
            frame.push_back(HEAD_BYTE);
            body_len = $urandom_range(0, 10);
            for (int i = 0; i < body_len; i++)
                frame.push_back(($urandom_range(0, 5) == 0) ? STAR_BYTE
                                                            : 8'($urandom_range(0, 255)));
        end
        else
        begin
            body_len = $urandom_range(1, 6);
            for (int i = 0; i < body_len; i++)
                frame.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int calm_start;
        calm_start = $urandom_range(400, 1200);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored while idle, then empty, typed, lowercase digits, head and star as data
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$*00");
        send_text("$GPGGA*56");
        send_text("$a*ff");
        send_text("$$**0");

        while (used_bytes < BYTE_TARGET)
        begin
            calm = (used_bytes >= calm_start) && (used_bytes < calm_start + 300);
            make_sentence();
            foreach (frame[i])
                send_byte(frame[i]);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending_sentences.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_sentences.size() != 0)
            sb.report_mismatch("sentences still outstanding at end");

        if (sb.errors == 0)
            $display("nmea_sentence_deframer_tb OK");
        else
            $display("nmea_sentence_deframer_tb NOT OK");
        $finish;
    end

endmodule
